// File: src/cvpr_pkg.sv
package cvpr_pkg;

	localparam int DATA_W = 16;

	localparam logic [1:0] FUNC_START = 2'd0;
	localparam logic [1:0] FUNC_READ  = 2'd1;
	localparam logic [1:0] FUNC_WRITE = 2'd2;
	localparam logic [1:0] FUNC_STOP  = 2'd3;

	localparam logic [1:0] STATUS_OK          = 2'd0;
	localparam logic [1:0] STATUS_UNSUPPORTED = 2'd1;
	localparam logic [1:0] STATUS_IGNORED     = 2'd2;

	localparam logic [DATA_W-1:0] BROADCAST_ADDR = 16'hFFFF;

	typedef struct packed {
		logic [1:0]        func;
		logic [DATA_W-1:0] article;
		logic [DATA_W-1:0] module_addr;
		logic [DATA_W-1:0] value;
		logic              in_range;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [DATA_W-1:0] read_data;
		logic              wr_en;
		logic              set_mode;
		logic              clr_mode;
	} eval_t;

endpackage

// File: src/cvpr_ram.sv
module cvpr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: src/cvpr_eval.sv
module cvpr_eval (
	input  cvpr_pkg::req_t              req,
	input  logic [cvpr_pkg::DATA_W-1:0] article_number,
	input  logic                        prog_active,
	input  logic [cvpr_pkg::DATA_W-1:0] entry,
	output cvpr_pkg::eval_t             res
);
	import cvpr_pkg::*;

	logic art_ok;
	logic prog_ok;

	assign art_ok  = (req.article == article_number);
	assign prog_ok = prog_active && art_ok;

	always_comb begin
		res           = '0;
		res.status    = STATUS_IGNORED;
		res.read_data = '0;
		case (req.func)
			FUNC_START: begin
				if (art_ok) begin
					// own address wins over broadcast when they are equal
					if (req.module_addr == entry) begin
						res.status    = STATUS_OK;
						res.read_data = entry;
						res.set_mode  = 1'b1;
					end else if (req.module_addr == BROADCAST_ADDR) begin
						res.status    = STATUS_OK;
						res.read_data = entry;
					end
				end
			end
			FUNC_READ: begin
				if (prog_ok) begin
					if (req.in_range) begin
						res.status    = STATUS_OK;
						res.read_data = entry;
					end else begin
						res.status = STATUS_UNSUPPORTED;
					end
				end
			end
			FUNC_WRITE: begin
				if (prog_ok) begin
					if (req.in_range) begin
						res.status = STATUS_OK;
						res.wr_en  = 1'b1;
					end else begin
						res.status = STATUS_UNSUPPORTED;
					end
				end
			end
			FUNC_STOP: begin
				if (prog_ok) begin
					res.status   = STATUS_OK;
					res.clr_mode = 1'b1;
				end
			end
			default: begin
				res.status = STATUS_IGNORED;
			end
		endcase
	end

endmodule

// File: src/config_variable_programming_responder_unit.sv
// channel   direction  handshake            payload
// request   in         in_valid / in_ready  func, request_article, cv_address,
//                                           module_address, write_value
// response  out        out_valid/out_ready  status, read_data
// config    in         cfg_we               cfg_wdata (article number)
//
// each request goes through two steps: the table read, then evaluate and write back
// the response sits in an output register, so a new request is taken while it waits
// a full output register with out_ready low holds the evaluate cycle
// reset clears the mode flag, the article number and the per-entry valid bits;
// an entry never written reads as zero, so no clearing pass is needed
module config_variable_programming_responder_unit #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  func,
	input  logic [cvpr_pkg::DATA_W-1:0] request_article,
	input  logic [cvpr_pkg::DATA_W-1:0] cv_address,
	input  logic [cvpr_pkg::DATA_W-1:0] module_address,
	input  logic [cvpr_pkg::DATA_W-1:0] write_value,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  status,
	output logic [cvpr_pkg::DATA_W-1:0] read_data,
	input  logic                        cfg_we,
	input  logic [cvpr_pkg::DATA_W-1:0] cfg_wdata
);
	import cvpr_pkg::*;

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	typedef enum logic {
		ST_IDLE,
		ST_EVAL
	} state_t;

	state_t               state_q;
	logic [DATA_W-1:0]    article_q;
	logic                 prog_q;
	logic [TABLE_DEPTH-1:0] valid_q;
	req_t                 req_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic                 out_valid_q;
	logic [1:0]           status_q;
	logic [DATA_W-1:0]    read_data_q;

	logic                 in_accept;
	logic                 advance;
	logic                 in_range;
	logic [IDX_W-1:0]     rd_idx;
	logic [DATA_W-1:0]    ram_rdata;
	logic [DATA_W-1:0]    entry;
	logic                 ram_we;
	eval_t                ev;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_accept = in_valid && in_ready;
	assign advance   = (state_q == ST_EVAL) && (!out_valid_q || out_ready);

	assign in_range = ({1'b0, cv_address} < 17'(TABLE_DEPTH));
	// start always looks at entry 0, the module address
	assign rd_idx   = (func == FUNC_START) ? '0 : cv_address[IDX_W-1:0];

	cvpr_ram #(
		.WIDTH(DATA_W),
		.DEPTH(TABLE_DEPTH),
		.AW   (IDX_W)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(idx_s1),
		.wdata(req_s1.value),
		.re   (in_accept),
		.raddr(rd_idx),
		.rdata(ram_rdata)
	);

	assign entry = valid_q[idx_s1] ? ram_rdata : '0;

	cvpr_eval u_eval (
		.req           (req_s1),
		.article_number(article_q),
		.prog_active   (prog_q),
		.entry         (entry),
		.res           (ev)
	);

	assign ram_we = advance && ev.wr_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			article_q <= '0;
		end else if (cfg_we) begin
			article_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prog_q      <= 1'b0;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						req_s1.func        <= func;
						req_s1.article     <= request_article;
						req_s1.module_addr <= module_address;
						req_s1.value       <= write_value;
						req_s1.in_range    <= in_range;
						idx_s1             <= rd_idx;
						state_q            <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (advance) begin
						status_q    <= ev.status;
						read_data_q <= ev.read_data;
						if (ev.set_mode) begin
							prog_q <= 1'b1;
						end else if (ev.clr_mode) begin
							prog_q <= 1'b0;
						end
						if (ev.wr_en) begin
							valid_q[idx_s1] <= 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign read_data = read_data_q;

endmodule
